### src/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg: shared definitions for the positional list buffer
// Sizes, request codes, status codes and the controller command bundle.
// ----------------------------------------------------------------------------
package plb_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int POS_W  = 5;
   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_INSERT     = 3'd4,
      OP_REMOVE     = 3'd5,
      OP_READ       = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   typedef struct packed {
      logic load;   // capture the request beat
      logic exec;   // apply the request and load the response registers
   } cmd_type;

endpackage

### src/plb_ctrl.sv
// ----------------------------------------------------------------------------
// plb_ctrl: request sequencer
// Accepts one request beat, runs it through the datapath, and owns the
// response valid flag.
// ----------------------------------------------------------------------------
module plb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output plb_pkg::cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   assign cmd.load  = req_valid && req_ready_ff;
   assign cmd.exec  = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         // response slot: fill on execute, drop when taken
         if (cmd.exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (cmd.load) begin
                  state_ff     <= S_EXEC;
                  req_ready_ff <= 1'b0;
               end
            end
            S_EXEC: begin
               if (cmd.exec) begin
                  state_ff     <= S_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

### src/plb_dp.sv
// ----------------------------------------------------------------------------
// plb_dp: list storage and request datapath
// Shift-chain entry storage, request registers and response registers.
// ----------------------------------------------------------------------------
module plb_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  plb_pkg::cmd_type                  cmd,
   input  logic        [plb_pkg::OP_W-1:0]   req_op,
   input  logic        [plb_pkg::POS_W-1:0]  req_position,
   input  logic signed [plb_pkg::DATA_W-1:0] req_data_in,
   output logic signed [plb_pkg::DATA_W-1:0] rsp_read_value,
   output logic signed [plb_pkg::DATA_W-1:0] rsp_front_value,
   output logic signed [plb_pkg::DATA_W-1:0] rsp_back_value,
   output logic        [plb_pkg::CNT_W-1:0]  rsp_count,
   output logic                              rsp_is_empty,
   output logic        [1:0]                 rsp_status
);

   localparam int DEPTH  = plb_pkg::DEPTH;
   localparam int IDX_W  = plb_pkg::IDX_W;
   localparam int CNT_W  = plb_pkg::CNT_W;
   localparam int CMP_W  = plb_pkg::CMP_W;
   localparam int DATA_W = plb_pkg::DATA_W;

   // request registers
   plb_pkg::op_type           op_ff;
   logic [plb_pkg::POS_W-1:0] pos_ff;
   logic [DATA_W-1:0]         data_ff;

   // list state
   logic [DATA_W-1:0] entries_ff [DEPTH];
   logic [DATA_W-1:0] entries_in [DEPTH];
   logic [DATA_W-1:0] shr        [DEPTH];
   logic [DATA_W-1:0] shl        [DEPTH];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [DATA_W-1:0] back_ff;
   logic [DATA_W-1:0] back_in;

   // response registers
   logic [DATA_W-1:0]    read_value_ff;
   logic [DATA_W-1:0]    front_value_ff;
   logic [DATA_W-1:0]    back_value_ff;
   logic [CNT_W-1:0]     count_out_ff;
   logic                 is_empty_ff;
   plb_pkg::status_type  status_ff;

   // decode
   logic                full;
   logic                ins_en;
   logic                rem_en;
   logic                rd_hit;
   logic                rem_last;
   logic [CMP_W-1:0]    at;
   logic [CMP_W-1:0]    pos_ext;
   logic [CMP_W-1:0]    cnt_ext;
   logic [CMP_W-1:0]    cnt_m1;
   logic [CNT_W-1:0]    cnt_m2;
   logic [IDX_W-1:0]    rd_addr;
   logic [DATA_W-1:0]   rd_data;
   plb_pkg::status_type status;

   assign pos_ext = CMP_W'(pos_ff);
   assign cnt_ext = CMP_W'(count_ff);
   assign cnt_m1  = cnt_ext - CMP_W'(1);
   assign cnt_m2  = count_ff - CNT_W'(2);
   assign full    = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      ins_en = 1'b0;
      rem_en = 1'b0;
      rd_hit = 1'b0;
      at     = '0;
      status = plb_pkg::ST_OK;
      unique case (op_ff)
         plb_pkg::OP_PUSH_FRONT: begin
            if (full) status = plb_pkg::ST_FULL;
            else ins_en = 1'b1;
         end
         plb_pkg::OP_PUSH_BACK: begin
            at = cnt_ext;
            if (full) status = plb_pkg::ST_FULL;
            else ins_en = 1'b1;
         end
         plb_pkg::OP_POP_FRONT: begin
            if (count_ff == '0) status = plb_pkg::ST_EMPTY;
            else rem_en = 1'b1;
         end
         plb_pkg::OP_POP_BACK: begin
            at = cnt_m1;
            if (count_ff == '0) status = plb_pkg::ST_EMPTY;
            else rem_en = 1'b1;
         end
         plb_pkg::OP_INSERT: begin
            at = pos_ext;
            if (full) status = plb_pkg::ST_FULL;
            else if (pos_ext > cnt_ext) status = plb_pkg::ST_BADPOS;
            else ins_en = 1'b1;
         end
         plb_pkg::OP_REMOVE: begin
            at = pos_ext;
            if (pos_ext >= cnt_ext) status = plb_pkg::ST_BADPOS;
            else rem_en = 1'b1;
         end
         plb_pkg::OP_READ: begin
            if (pos_ext >= cnt_ext) status = plb_pkg::ST_BADPOS;
            else rd_hit = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // single read port: the read position, or the new last entry after
   // removing the old last one
   assign rem_last = rem_en && (at == cnt_m1);
   assign rd_addr  = rem_last ? cnt_m2[IDX_W-1:0] : IDX_W'(pos_ext);
   assign rd_data  = entries_ff[rd_addr];

   always_comb begin
      shr[0]       = data_ff;
      shl[DEPTH-1] = entries_ff[DEPTH-1];
      for (int i = 1; i < DEPTH; i++) begin
         shr[i] = entries_ff[i-1];
      end
      for (int i = 0; i < DEPTH - 1; i++) begin
         shl[i] = entries_ff[i+1];
      end
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
         if (ins_en) begin
            if (CMP_W'(i) == at) entries_in[i] = data_ff;
            else if (CMP_W'(i) > at) entries_in[i] = shr[i];
         end else if (rem_en) begin
            if (CMP_W'(i) >= at) entries_in[i] = shl[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      back_in  = back_ff;
      if (ins_en) begin
         count_in = count_ff + CNT_W'(1);
         if (at == cnt_ext) back_in = data_ff;
      end else if (rem_en) begin
         count_in = count_ff - CNT_W'(1);
         if (rem_last) back_in = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= plb_pkg::op_type'(req_op);
         pos_ff  <= req_position;
         data_ff <= req_data_in;
      end
      if (cmd.exec) begin
         for (int i = 0; i < DEPTH; i++) begin
            entries_ff[i] <= entries_in[i];
         end
         back_ff        <= back_in;
         read_value_ff  <= rd_hit ? rd_data : '0;
         front_value_ff <= (count_in != '0) ? entries_in[0] : '0;
         back_value_ff  <= (count_in != '0) ? back_in : '0;
         count_out_ff   <= count_in;
         is_empty_ff    <= (count_in == '0);
         status_ff      <= status;
      end
   end

   assign rsp_read_value  = read_value_ff;
   assign rsp_front_value = front_value_ff;
   assign rsp_back_value  = back_value_ff;
   assign rsp_count       = count_out_ff;
   assign rsp_is_empty    = is_empty_ff;
   assign rsp_status      = status_ff;

endmodule

### src/positional_list_buffer.sv
// ----------------------------------------------------------------------------
// positional_list_buffer: bounded ordered list with positional access
// Holds up to DEPTH signed 32-bit words in a shift chain and serves push/pop
// at either end, insert/remove at a position and read at a position.
// ----------------------------------------------------------------------------
// Each request beat yields exactly one response beat carrying the value read
// (zero unless a successful read), the front and back entries and the count
// after the request, an empty flag and a status (ok, full, empty, bad
// position); a failed request leaves the list untouched. A request is first
// registered as a beat; the whole shift chain then moves and the response
// registers load, and a new request is taken only once the previous one has
// executed. The next request is taken while an earlier response still
// waits on rsp_ready; it then stalls in its execute cycle until the response
// register frees up. Entry storage starts out undefined; only entries below
// the count are ever shown, so no clearing pass runs after reset.
module positional_list_buffer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic        [plb_pkg::OP_W-1:0]   req_op,
   input  logic        [plb_pkg::POS_W-1:0]  req_position,
   input  logic signed [plb_pkg::DATA_W-1:0] req_data_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [plb_pkg::DATA_W-1:0] rsp_read_value,
   output logic signed [plb_pkg::DATA_W-1:0] rsp_front_value,
   output logic signed [plb_pkg::DATA_W-1:0] rsp_back_value,
   output logic        [plb_pkg::CNT_W-1:0]  rsp_count,
   output logic                              rsp_is_empty,
   output logic        [1:0]                 rsp_status
);

   plb_pkg::cmd_type cmd;

   // sequencer: hand-off of beats and the response valid flag
   plb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // storage, decode and response registers
   plb_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_op),
      .req_position    (req_position),
      .req_data_in     (req_data_in),
      .rsp_read_value  (rsp_read_value),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_count       (rsp_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

endmodule

### src/plb_checker.sv
// ----------------------------------------------------------------------------
// plb_checker: port-level checks for the positional list buffer
// Watches the response channel for consistency of the reported list state.
// ----------------------------------------------------------------------------
module plb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [plb_pkg::DATA_W-1:0] rsp_read_value,
   input logic signed [plb_pkg::DATA_W-1:0] rsp_front_value,
   input logic signed [plb_pkg::DATA_W-1:0] rsp_back_value,
   input logic        [plb_pkg::CNT_W-1:0]  rsp_count,
   input logic                              rsp_is_empty,
   input logic        [1:0]                 rsp_status
);

   // a stalled response beat holds its read value, count and status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_count) && $stable(rsp_status))
      else $error("response beat changed while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_count == '0))
         && (rsp_count <= plb_pkg::CNT_W'(plb_pkg::DEPTH)))
      else $error("empty flag or count inconsistent");

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_front_value == '0 && rsp_back_value == '0
         && rsp_read_value == '0)
      else $error("empty list shows nonzero values");

   a_status_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != plb_pkg::ST_EMPTY || rsp_is_empty)
         && (rsp_status != plb_pkg::ST_FULL
             || rsp_count == plb_pkg::CNT_W'(plb_pkg::DEPTH)))
      else $error("status disagrees with list fill");

endmodule

bind positional_list_buffer plb_checker u_plb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_read_value  (rsp_read_value),
   .rsp_front_value (rsp_front_value),
   .rsp_back_value  (rsp_back_value),
   .rsp_count       (rsp_count),
   .rsp_is_empty    (rsp_is_empty),
   .rsp_status      (rsp_status)
);
